// ===== hdl/nat_pkg.sv =====
// shared types, codes and sizes for the neighbour adjacency table
package nat_pkg;

    localparam int MAX_NEIGHBORS = 16;
    localparam int IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

    localparam int ID_W    = 48;
    localparam int TIME_W  = 32;
    localparam int TIMER_W = 16;
    localparam int CNT_W   = 5;

    // request codes
    localparam logic [1:0] REQ_HELLO      = 2'd0;
    localparam logic [1:0] REQ_TICK       = 2'd1;
    localparam logic [1:0] REQ_HELLO_SENT = 2'd2;
    localparam logic [1:0] REQ_QUERY      = 2'd3;

    // neighbour states
    localparam logic [1:0] NS_DOWN = 2'd0;
    localparam logic [1:0] NS_INIT = 2'd1;
    localparam logic [1:0] NS_UP   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_OWN_ID   = 2'd0;
    localparam logic [1:0] CFG_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_MULT     = 2'd2;

    localparam logic [TIMER_W-1:0] INTERVAL_DEFAULT = 16'd15;
    localparam logic [TIMER_W-1:0] MULT_DEFAULT     = 16'd3;

    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    node_id;
        logic [1:0]         state;
        logic               two_way;
        logic [TIMER_W-1:0] adv_timer;
        logic [TIME_W-1:0]  deadline;
    } entry_t;

    typedef struct packed {
        logic hit;
        logic vacant;
        logic expired;
    } cmp_t;

endpackage

// ===== hdl/nat_store.sv =====
// neighbour entry storage: one read and one write address per cycle
module nat_store (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [nat_pkg::IDX_W-1:0]   rd_idx,
    output nat_pkg::entry_t             rd_entry,
    input  logic                        wr_en,
    input  logic [nat_pkg::IDX_W-1:0]   wr_idx,
    input  nat_pkg::entry_t             wr_entry
);

    logic                            valid_reg [nat_pkg::MAX_NEIGHBORS];
    logic [nat_pkg::ID_W-1:0]        id_reg    [nat_pkg::MAX_NEIGHBORS];
    logic [1:0]                      state_reg [nat_pkg::MAX_NEIGHBORS];
    logic                            tw_reg    [nat_pkg::MAX_NEIGHBORS];
    logic [nat_pkg::TIMER_W-1:0]     adv_reg   [nat_pkg::MAX_NEIGHBORS];
    logic [nat_pkg::TIME_W-1:0]      dl_reg    [nat_pkg::MAX_NEIGHBORS];

    // valid bits are the only cleared part
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < nat_pkg::MAX_NEIGHBORS; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (wr_en) begin
            valid_reg[wr_idx] <= wr_entry.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            id_reg[wr_idx]    <= wr_entry.node_id;
            state_reg[wr_idx] <= wr_entry.state;
            tw_reg[wr_idx]    <= wr_entry.two_way;
            adv_reg[wr_idx]   <= wr_entry.adv_timer;
            dl_reg[wr_idx]    <= wr_entry.deadline;
        end
    end

    always_comb begin
        rd_entry.valid     = valid_reg[rd_idx];
        rd_entry.node_id   = id_reg[rd_idx];
        rd_entry.state     = state_reg[rd_idx];
        rd_entry.two_way   = tw_reg[rd_idx];
        rd_entry.adv_timer = adv_reg[rd_idx];
        rd_entry.deadline  = dl_reg[rd_idx];
    end

endmodule

// ===== hdl/nat_cmp_unit.sv =====
// shared entry compare: id match, free slot and deadline reached
module nat_cmp_unit (
    input  nat_pkg::entry_t                 entry,
    input  logic [nat_pkg::ID_W-1:0]        key_id,
    input  logic [nat_pkg::TIME_W-1:0]      now,
    output nat_pkg::cmp_t                   res
);

    always_comb begin
        res.hit     = entry.valid && (entry.node_id == key_id);
        res.vacant  = !entry.valid;
        res.expired = entry.valid && (entry.state != nat_pkg::NS_DOWN)
                      && (now >= entry.deadline);
    end

endmodule

// ===== hdl/neighbor_adjacency_table.sv =====
// top level of the neighbour adjacency table: sequencer, registers and result stage
// sweep of one entry per cycle through a shared compare unit; a hello runs scan,
// multiply, write-back (if it has a slot) and finish; tick and query run scan and
// finish, hello sent straight to finish; a new request is taken while a result waits
// synchronous active-low reset of valid bits, sequencer, result valid, next hello time, config
module neighbor_adjacency_table (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [nat_pkg::ID_W-1:0]        cfg_data,
    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_req_type,
    input  logic [nat_pkg::TIME_W-1:0]      s_now,
    input  logic [nat_pkg::ID_W-1:0]        s_sender_id,
    input  logic [nat_pkg::ID_W-1:0]        s_named_neighbor_id,
    input  logic [nat_pkg::TIMER_W-1:0]     s_advertised_timer,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_status,
    output logic [1:0]                      m_neighbor_state,
    output logic [nat_pkg::CNT_W-1:0]       m_downed_count,
    output logic                            m_hello_due
);

    // sequencer codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_WRITE  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    localparam logic [nat_pkg::IDX_W-1:0] LAST_IDX =
        nat_pkg::IDX_W'(nat_pkg::MAX_NEIGHBORS - 1);
    localparam logic [nat_pkg::CNT_W-1:0] CNT_MAX = '1;

    // configuration registers
    logic [nat_pkg::ID_W-1:0]    own_id_reg;
    logic [nat_pkg::TIMER_W-1:0] interval_reg;
    logic [nat_pkg::TIMER_W-1:0] mult_reg;

    // sequencer and request registers
    logic [2:0]                  state_reg, state_next;
    logic [1:0]                  req_reg;
    logic [nat_pkg::TIME_W-1:0]  now_reg;
    logic [nat_pkg::ID_W-1:0]    sender_reg;
    logic [nat_pkg::ID_W-1:0]    named_reg;
    logic [nat_pkg::TIMER_W-1:0] adv_reg;
    logic [nat_pkg::IDX_W-1:0]   idx_reg;
    logic                        found_reg;
    logic [nat_pkg::IDX_W-1:0]   found_idx_reg;
    logic                        free_reg;
    logic [nat_pkg::IDX_W-1:0]   free_idx_reg;
    logic [nat_pkg::IDX_W-1:0]   k_reg;
    logic                        fresh_reg;
    logic [nat_pkg::TIME_W-1:0]  prod_reg;
    logic                        status_reg;
    logic [1:0]                  nstate_reg;
    logic [nat_pkg::CNT_W-1:0]   downed_reg;
    logic [nat_pkg::TIME_W-1:0]  next_hello_reg;

    // result stage
    logic                        m_valid_reg;
    logic                        m_status_reg;
    logic [1:0]                  m_nstate_reg;
    logic [nat_pkg::CNT_W-1:0]   m_downed_reg;
    logic                        m_due_reg;

    // store and compare unit wiring
    logic [nat_pkg::IDX_W-1:0]   rd_idx;
    nat_pkg::entry_t             rd_entry;
    logic                        wr_en;
    logic [nat_pkg::IDX_W-1:0]   wr_idx;
    nat_pkg::entry_t             wr_entry;
    nat_pkg::cmp_t               cmp;

    // working values
    logic [nat_pkg::TIMER_W-1:0] eff_interval;
    logic [nat_pkg::TIMER_W-1:0] eff_mult;
    logic [nat_pkg::TIMER_W-1:0] adv_eff;
    logic [nat_pkg::TIME_W:0]    dl_sum;
    logic [nat_pkg::TIME_W-1:0]  dl_sat;
    logic [nat_pkg::TIME_W:0]    nh_sum;
    logic [nat_pkg::TIME_W-1:0]  nh_sat;
    logic                        two_way;
    logic [1:0]                  old_state;
    logic [1:0]                  new_state;
    logic                        in_xfer;
    logic                        out_load;

    // zero registers fall back to the defaults, a zero advertised timer to the interval
    assign eff_interval = (interval_reg == '0) ? nat_pkg::INTERVAL_DEFAULT : interval_reg;
    assign eff_mult     = (mult_reg == '0) ? nat_pkg::MULT_DEFAULT : mult_reg;
    assign adv_eff      = (adv_reg == '0) ? eff_interval : adv_reg;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_load = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    // next hello time, saturating add on the incoming time
    assign nh_sum = {1'b0, s_now} + {{(nat_pkg::TIME_W - nat_pkg::TIMER_W + 1){1'b0}}, eff_interval};
    assign nh_sat = nh_sum[nat_pkg::TIME_W] ? '1 : nh_sum[nat_pkg::TIME_W-1:0];

    // listen deadline from the registered product
    assign dl_sum = {1'b0, now_reg} + {1'b0, prod_reg};
    assign dl_sat = dl_sum[nat_pkg::TIME_W] ? '1 : dl_sum[nat_pkg::TIME_W-1:0];

    // one read port: scan position during the sweep, chosen slot on write-back
    assign rd_idx = (state_reg == ST_WRITE) ? k_reg : idx_reg;

    nat_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_entry (wr_entry)
    );

    nat_cmp_unit u_cmp (
        .entry  (rd_entry),
        .key_id (sender_reg),
        .now    (now_reg),
        .res    (cmp)
    );

    // adjacency transition for the hello write-back
    always_comb begin
        two_way   = (named_reg == own_id_reg);
        old_state = fresh_reg ? nat_pkg::NS_DOWN : rd_entry.state;
        case (old_state)
            nat_pkg::NS_DOWN: new_state = two_way ? nat_pkg::NS_UP : nat_pkg::NS_INIT;
            nat_pkg::NS_INIT: new_state = two_way ? nat_pkg::NS_UP : nat_pkg::NS_INIT;
            default:          new_state = old_state;
        endcase
    end

    // table write port: tick downs an entry in place, hello rewrites its slot
    always_comb begin
        wr_en    = 1'b0;
        wr_idx   = idx_reg;
        wr_entry = rd_entry;
        if (state_reg == ST_SCAN && req_reg == nat_pkg::REQ_TICK && cmp.expired) begin
            wr_en            = 1'b1;
            wr_entry.state   = nat_pkg::NS_DOWN;
            wr_entry.two_way = 1'b0;
        end else if (state_reg == ST_WRITE) begin
            wr_en              = 1'b1;
            wr_idx             = k_reg;
            wr_entry.valid     = 1'b1;
            wr_entry.node_id   = sender_reg;
            wr_entry.state     = new_state;
            wr_entry.two_way   = two_way;
            wr_entry.adv_timer = adv_eff;
            wr_entry.deadline  = dl_sat;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_req_type == nat_pkg::REQ_HELLO_SENT) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (idx_reg == LAST_IDX) begin
                    state_next = (req_reg == nat_pkg::REQ_HELLO) ? ST_MUL : ST_FINISH;
                end
            end
            ST_MUL: begin
                state_next = (found_reg || free_reg) ? ST_WRITE : ST_FINISH;
            end
            ST_WRITE: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state, config, next hello time and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            own_id_reg     <= '0;
            interval_reg   <= nat_pkg::INTERVAL_DEFAULT;
            mult_reg       <= nat_pkg::MULT_DEFAULT;
            next_hello_reg <= {{(nat_pkg::TIME_W - nat_pkg::TIMER_W){1'b0}},
                               nat_pkg::INTERVAL_DEFAULT};
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    nat_pkg::CFG_OWN_ID:   own_id_reg   <= cfg_data;
                    nat_pkg::CFG_INTERVAL: interval_reg <= cfg_data[nat_pkg::TIMER_W-1:0];
                    nat_pkg::CFG_MULT:     mult_reg     <= cfg_data[nat_pkg::TIMER_W-1:0];
                    default: ;
                endcase
            end
            // hello sent rearms on the input transfer itself
            if (in_xfer && s_req_type == nat_pkg::REQ_HELLO_SENT) begin
                next_hello_reg <= nh_sat;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request payload and sweep bookkeeping
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            req_reg    <= s_req_type;
            now_reg    <= s_now;
            sender_reg <= s_sender_id;
            named_reg  <= s_named_neighbor_id;
            adv_reg    <= s_advertised_timer;
            idx_reg    <= '0;
            found_reg  <= 1'b0;
            free_reg   <= 1'b0;
            status_reg <= 1'b0;
            nstate_reg <= nat_pkg::NS_DOWN;
            downed_reg <= '0;
        end
        case (state_reg)
            ST_SCAN: begin
                idx_reg <= idx_reg + 1'b1;
                // first matching id and lowest free slot
                if (cmp.hit && !found_reg) begin
                    found_reg     <= 1'b1;
                    found_idx_reg <= idx_reg;
                    if (req_reg == nat_pkg::REQ_QUERY) begin
                        nstate_reg <= rd_entry.state;
                    end
                end
                if (cmp.vacant && !free_reg) begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= idx_reg;
                end
                if (req_reg == nat_pkg::REQ_TICK && cmp.expired && downed_reg != CNT_MAX) begin
                    downed_reg <= downed_reg + 1'b1;
                end
            end
            ST_MUL: begin
                k_reg     <= found_reg ? found_idx_reg : free_idx_reg;
                fresh_reg <= !found_reg;
                prod_reg  <= {{(nat_pkg::TIME_W - nat_pkg::TIMER_W){1'b0}}, eff_mult}
                             * {{(nat_pkg::TIME_W - nat_pkg::TIMER_W){1'b0}}, adv_eff};
                if (!found_reg && !free_reg) begin
                    status_reg <= 1'b1;
                end
            end
            ST_WRITE: begin
                nstate_reg <= new_state;
            end
            default: ;
        endcase
    end

    // result register, hello due taken after this request's update
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= status_reg;
            m_nstate_reg <= nstate_reg;
            m_downed_reg <= downed_reg;
            m_due_reg    <= (now_reg >= next_hello_reg);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_neighbor_state = m_nstate_reg;
    assign m_downed_count   = m_downed_reg;
    assign m_hello_due      = m_due_reg;

endmodule

// ===== tb/sv/tb_neighbor_adjacency_table.sv =====
// self-checking testbench for the neighbour adjacency table, directed and random requests
module tb_neighbor_adjacency_table;
    import nat_pkg::*;

    // no transfer for this many cycles while work is outstanding ends the run
    localparam int WATCHDOG_CYCLES = 3000;
    // the one long receiver hold-off, long enough to back the block up into its input
    localparam int HOLD_OFF_CYCLES = 400;
    // settling time after the last result, well past the longest sweep
    localparam int DRAIN_CYCLES    = 30;
    // cap on printed mismatch lines, failures are still counted past it
    localparam int MAX_REPORTS     = 40;

    typedef struct packed {
        logic [1:0]         req;
        logic [TIME_W-1:0]  now;
        logic [ID_W-1:0]    sender;
        logic [ID_W-1:0]    named;
        logic [TIMER_W-1:0] adv;
    } request_t;

    typedef struct packed {
        logic             status;
        logic [1:0]       nstate;
        logic [CNT_W-1:0] downed;
        logic             due;
    } reply_t;

    // receiver behaviour, re-chosen at random during the run
    typedef enum int {RX_OPEN, RX_ALTERNATE, RX_RANDOM, RX_SPARSE} rx_mode_e;

    // every block input holds a known value from time zero
    logic                aclk                = 1'b0;
    logic                aresetn             = 1'b0;
    logic                cfg_we              = 1'b0;
    logic [1:0]          cfg_index           = CFG_OWN_ID;
    logic [ID_W-1:0]     cfg_data            = '0;
    logic                s_valid             = 1'b0;
    logic                s_ready;
    logic [1:0]          s_req_type          = REQ_HELLO;
    logic [TIME_W-1:0]   s_now               = '0;
    logic [ID_W-1:0]     s_sender_id         = '0;
    logic [ID_W-1:0]     s_named_neighbor_id = '0;
    logic [TIMER_W-1:0]  s_advertised_timer  = '0;
    logic                m_valid;
    logic                m_ready             = 1'b0;
    logic                m_status;
    logic [1:0]          m_neighbor_state;
    logic [CNT_W-1:0]    m_downed_count;
    logic                m_hello_due;

    neighbor_adjacency_table dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_req_type          (s_req_type),
        .s_now               (s_now),
        .s_sender_id         (s_sender_id),
        .s_named_neighbor_id (s_named_neighbor_id),
        .s_advertised_timer  (s_advertised_timer),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_neighbor_state    (m_neighbor_state),
        .m_downed_count      (m_downed_count),
        .m_hello_due         (m_hello_due)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // predicted neighbour table; the two-way flag and the stored timer
    // never reach the outputs, so only what they feed is kept here
    // ------------------------------------------------------------------
    logic               tbl_valid    [MAX_NEIGHBORS] = '{default: 1'b0};
    logic [ID_W-1:0]    tbl_id       [MAX_NEIGHBORS];
    logic [1:0]         tbl_state    [MAX_NEIGHBORS];
    logic [TIME_W-1:0]  tbl_deadline [MAX_NEIGHBORS];
    logic [TIME_W-1:0]  next_hello_at = TIME_W'(INTERVAL_DEFAULT);

    // register copies, reset values
    logic [ID_W-1:0]    my_id       = '0;
    logic [TIMER_W-1:0] hello_ticks = INTERVAL_DEFAULT;
    logic [TIMER_W-1:0] listen_mult = MULT_DEFAULT;

    request_t requests_to_send [$];
    reply_t   expected_replies [$];

    logic [ID_W-1:0]    known_ids [MAX_NEIGHBORS];
    logic [TIME_W-1:0]  tick_now = '0;

    int reqs_offered   = 0;
    int reqs_accepted  = 0;
    int errors         = 0;
    int stalled_cycles = 0;
    int settings_run   = 1;

    // tallies for the closing summary
    int n_hello = 0, n_full = 0, n_tick = 0, n_downed = 0;
    int n_query = 0, n_sent = 0, n_due = 0;

    // sender pacing
    int burst_left = 1;
    int gap_left   = 0;

    // receiver pacing and the long hold-off
    bit       hold_req  = 1'b0;
    bit       hold_done = 1'b0;
    int       hold_left = 0;
    int       mode_left = 0;
    int       rx_cycle  = 0;
    rx_mode_e rx_mode   = RX_OPEN;

    // times saturate at all ones instead of wrapping
    function automatic logic [TIME_W-1:0] sat_time(logic [TIME_W-1:0] base,
                                                   logic [TIME_W-1:0] span);
        logic [TIME_W:0] sum;
        sum = {1'b0, base} + {1'b0, span};
        return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    endfunction

    function automatic int find_neighbour(logic [ID_W-1:0] id);
        for (int i = 0; i < MAX_NEIGHBORS; i++)
            if (tbl_valid[i] && tbl_id[i] == id)
                return i;
        return -1;
    endfunction

    // applies one request to the predicted table and returns its result
    function automatic reply_t adjacency_update(request_t r);
        reply_t             rep;
        int                 slot;
        logic [TIMER_W-1:0] interval;
        logic [TIMER_W-1:0] mult;
        logic [TIMER_W-1:0] timer;
        logic               two_way;
        rep      = '0;
        // a zero register falls back to its reset value
        interval = (hello_ticks == '0) ? INTERVAL_DEFAULT : hello_ticks;
        mult     = (listen_mult == '0) ? MULT_DEFAULT : listen_mult;
        case (r.req)
            REQ_HELLO: begin
                slot = find_neighbour(r.sender);
                if (slot < 0) begin
                    // lowest free slot wins, new entries start down
                    for (int i = MAX_NEIGHBORS - 1; i >= 0; i--)
                        if (!tbl_valid[i])
                            slot = i;
                    if (slot >= 0) begin
                        tbl_valid[slot] = 1'b1;
                        tbl_id[slot]    = r.sender;
                        tbl_state[slot] = NS_DOWN;
                    end
                end
                if (slot < 0) begin
                    rep.status = 1'b1;
                end else begin
                    timer   = (r.adv == '0) ? interval : r.adv;
                    two_way = (r.named == my_id);
                    tbl_deadline[slot] = sat_time(r.now, {16'd0, mult} * {16'd0, timer});
                    if (tbl_state[slot] == NS_DOWN)
                        tbl_state[slot] = two_way ? NS_UP : NS_INIT;
                    else if (tbl_state[slot] == NS_INIT && two_way)
                        tbl_state[slot] = NS_UP;
                    rep.nstate = tbl_state[slot];
                end
            end
            REQ_TICK: begin
                for (int i = 0; i < MAX_NEIGHBORS; i++)
                    if (tbl_valid[i] && tbl_state[i] != NS_DOWN && r.now >= tbl_deadline[i]) begin
                        tbl_state[i] = NS_DOWN;
                        if (rep.downed != '1)
                            rep.downed = rep.downed + 1'b1;
                    end
            end
            REQ_HELLO_SENT: begin
                next_hello_at = sat_time(r.now, {16'd0, interval});
            end
            REQ_QUERY: begin
                slot = find_neighbour(r.sender);
                if (slot >= 0)
                    rep.nstate = tbl_state[slot];
            end
            default: ;
        endcase
        // hello due is judged after this request's own update
        rep.due = (r.now >= next_hello_at);
        return rep;
    endfunction

    function automatic logic [ID_W-1:0] random_id();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic void compare_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // request driver: bursts of transfers with random gaps in between
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        request_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && reqs_accepted != reqs_offered)) begin
            // nothing on offer, or the last offer has been taken
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (requests_to_send.size() > 0) begin
                nxt = requests_to_send.pop_front();
                s_req_type          <= nxt.req;
                s_now               <= nxt.now;
                s_sender_id         <= nxt.sender;
                s_named_neighbor_id <= nxt.named;
                s_advertised_timer  <= nxt.adv;
                s_valid             <= 1'b1;
                reqs_offered++;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    // a quarter of bursts run straight into the next one
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // request transfers feed the predictor
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        reply_t rep;
        if (aresetn && s_valid && s_ready) begin
            rep = adjacency_update({s_req_type, s_now, s_sender_id,
                                    s_named_neighbor_id, s_advertised_timer});
            expected_replies.push_back(rep);
            reqs_accepted++;
            if (rep.due)
                n_due++;
            case (s_req_type)
                REQ_HELLO: begin
                    if (rep.status)
                        n_full++;
                    else
                        n_hello++;
                end
                REQ_TICK: begin
                    n_tick++;
                    n_downed += rep.downed;
                end
                REQ_HELLO_SENT: n_sent++;
                default: n_query++;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // receiver: stall pattern of its own plus one long hold-off
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (mode_left == 0) begin
            rx_mode   = rx_mode_e'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 80);
        end else begin
            mode_left--;
        end
        rx_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:      m_ready <= 1'b1;
                RX_ALTERNATE: m_ready <= (rx_cycle % 2 == 0);
                RX_RANDOM:    m_ready <= ($urandom_range(0, 9) > 2);
                default:      m_ready <= (rx_cycle % 8 == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result monitor: each result transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_replies.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t result with nothing expected: expected none, actual status %0d state %0d downed %0d due %0d",
                             $time, m_status, m_neighbor_state, m_downed_count, m_hello_due);
            end else begin
                want = expected_replies.pop_front();
                compare_field("status", want.status, m_status);
                compare_field("neighbor_state", want.nstate, m_neighbor_state);
                compare_field("downed_count", want.downed, m_downed_count);
                compare_field("hello_due", want.due, m_hello_due);
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: counts cycles with work outstanding but no transfer
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) ||
            (requests_to_send.size() == 0 && !s_valid && expected_replies.size() == 0))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t watchdog: no transfer for %0d cycles, %0d results outstanding",
                     $time, stalled_cycles, expected_replies.size());
            $display("** neighbor_adjacency_table: FAILED **");
            $finish;
        end
    end

    task automatic queue_request(logic [1:0] req, logic [TIME_W-1:0] now,
                                 logic [ID_W-1:0] sender, logic [ID_W-1:0] named,
                                 logic [TIMER_W-1:0] adv);
        request_t item;
        item = {req, now, sender, named, adv};
        requests_to_send.push_back(item);
    endtask

    // register write while the block is idle; the predictor copy follows at the edge
    task automatic write_reg(logic [1:0] index, logic [ID_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        case (index)
            CFG_OWN_ID:   my_id = value;
            CFG_INTERVAL: hello_ticks = value[TIMER_W-1:0];
            default:      listen_mult = value[TIMER_W-1:0];
        endcase
    endtask

    // waits until every request has been taken and every result has come back
    task automatic wait_drained();
        do
            @(posedge aclk);
        while (requests_to_send.size() != 0 || s_valid || expected_replies.size() != 0);
    endtask

    // random traffic on the filled table: mostly known neighbours so that states
    // keep cycling, a few strangers for dropped hellos and unknown queries
    task automatic queue_random(int count, int unsigned step_max);
        int unsigned        pick;
        logic [1:0]         req;
        logic [TIME_W-1:0]  at;
        logic [ID_W-1:0]    who;
        logic [ID_W-1:0]    named;
        logic [TIMER_W-1:0] adv;
        for (int n = 0; n < count; n++) begin
            tick_now = tick_now + $urandom_range(0, step_max);
            // now mostly moves forward, now and then it jumps anywhere
            at  = ($urandom_range(0, 24) == 0) ? TIME_W'($urandom) : tick_now;
            who = ($urandom_range(0, 6) == 0) ? random_id()
                                              : known_ids[$urandom_range(0, MAX_NEIGHBORS - 1)];
            case ($urandom_range(0, 3))
                0, 1:    named = my_id;
                2:       named = known_ids[$urandom_range(0, MAX_NEIGHBORS - 1)];
                default: named = random_id();
            endcase
            pick = $urandom_range(0, 9);
            adv  = (pick < 4) ? '0 :
                   (pick < 9) ? TIMER_W'($urandom_range(1, 8)) : TIMER_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 45)
                req = REQ_HELLO;
            else if (pick < 65)
                req = REQ_TICK;
            else if (pick < 80)
                req = REQ_HELLO_SENT;
            else
                req = REQ_QUERY;
            queue_request(req, at, who, named, adv);
        end
    endtask

    // one register setting: write all three, run random traffic, drain
    task automatic run_phase(logic [ID_W-1:0] own, logic [ID_W-1:0] interval_word,
                             logic [ID_W-1:0] mult_word, int unsigned step_max,
                             int count, bit squeeze);
        write_reg(CFG_OWN_ID, own);
        write_reg(CFG_INTERVAL, interval_word);
        write_reg(CFG_MULT, mult_word);
        @(negedge aclk);
        cfg_we <= 1'b0;
        settings_run++;
        queue_random(count, step_max);
        // receiver backs off while the sender keeps offering
        if (squeeze)
            hold_req = 1'b1;
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [ID_W-1:0] stray;
        // neighbour pool: both id extremes plus distinct random ids
        known_ids[0] = '0;
        known_ids[1] = '1;
        for (int i = 2; i < MAX_NEIGHBORS; i++)
            known_ids[i] = {32'($urandom), 16'hA000 + 16'(i)};
        stray = random_id();

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part under reset settings: own id 0, interval 15, multiplier 3
        queue_request(REQ_QUERY, 32'd0, known_ids[0], stray, 16'd0);      // empty table
        queue_request(REQ_HELLO_SENT, 32'd3, stray, random_id(), 16'hFFFF);
        // names our own id at once: down straight to up
        queue_request(REQ_HELLO, 32'd5, known_ids[0], '0, 16'd0);
        // one-way hello whose deadline saturates
        queue_request(REQ_HELLO, 32'hFFFF_FF00, known_ids[1], 48'h1234_5678_9ABC, 16'hFFFF);
        queue_request(REQ_HELLO, 32'd6, known_ids[1], '0, 16'd1);         // initialising to up
        queue_request(REQ_HELLO, 32'd7, known_ids[2], 48'd1, 16'd2);      // one-way
        // one deadline passed, one reached exactly, one still ahead
        queue_request(REQ_TICK, 32'd13, random_id(), random_id(), 16'h5A5A);
        queue_request(REQ_HELLO, 32'd20, known_ids[2], '0, 16'd0);        // back up
        queue_request(REQ_TICK, 32'hFFFF_FFFF, '1, '1, 16'hFFFF);         // everything goes down
        queue_request(REQ_HELLO_SENT, 32'hFFFF_FFF8, '0, '0, 16'd0);      // next hello saturates
        queue_request(REQ_QUERY, 32'hFFFF_FFFE, known_ids[0], stray, 16'd0);
        queue_request(REQ_QUERY, 32'hFFFF_FFFF, stray, stray, 16'd0);     // unknown, hello due
        queue_request(REQ_HELLO_SENT, 32'd21, stray, stray, 16'd0);
        // fill the rest of the table, then one stranger finds no free slot
        for (int i = 3; i < MAX_NEIGHBORS; i++)
            queue_request(REQ_HELLO, 32'(30 + i), known_ids[i], (i % 2 == 1) ? '0 : stray,
                          16'(i));
        queue_request(REQ_HELLO, 32'd50, stray, '0, 16'd4);
        wait_drained();

        tick_now = 32'd60;
        // shortest timers: deadlines one to a few ticks out
        run_phase(random_id(), 48'd1, 48'd1, 5, 231, 1'b0);
        // zero registers act as their reset values, own id all ones
        run_phase('1, 48'd0, 48'd0, 6, 231, 1'b0);
        // largest timers, long receiver hold-off in this setting
        run_phase(random_id(), 48'd65535, 48'd65535, 40000, 231, 1'b1);
        // mid-range values with junk in the unused upper data bits
        run_phase('0, {32'($urandom), 16'($urandom_range(2, 40))},
                  {32'($urandom), 16'($urandom_range(1, 6))}, 8, 231, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("run covered %0d requests over %0d register settings: %0d hellos taken, %0d dropped on a full table",
                 reqs_accepted, settings_run, n_hello, n_full);
        $display("%0d ticks took down %0d neighbours; %0d queries, %0d hellos sent, %0d results with hello due",
                 n_tick, n_downed, n_query, n_sent, n_due);
        if (errors == 0) begin
            $display("** neighbor_adjacency_table: PASSED **");
        end else begin
            $display("** neighbor_adjacency_table: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/nat_pkg.sv
hdl/nat_store.sv
hdl/nat_cmp_unit.sv
hdl/neighbor_adjacency_table.sv
tb/sv/tb_neighbor_adjacency_table.sv
